@@ hw/rtl/lrupb_pkg.sv @@
// Package for the LRU page buffer: sizes, command and result codes, FSM states.
// No dependencies.
`timescale 1ns / 1ps
package lrupb_pkg;
  localparam int SLOTS = 16;
  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    CMD_GET = 2'd0, CMD_PIN = 2'd1, CMD_MARK = 2'd2, CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    K_HIT = 3'd0, K_MISS = 3'd1, K_PIN_UPD = 3'd2, K_PIN_INS = 3'd3,
    K_MARKED = 3'd4, K_ABSENT = 3'd5, K_FLUSH_WB = 3'd6, K_FLUSH_DONE = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FREAD, S_FEMIT
  } state_t;
endpackage

@@ hw/rtl/lru_page_buffer_policy.sv @@
// LRU page buffer top level: tag memory, per-slot flags and age counters, control FSM.
// Depends on lrupb_pkg.
// Get, pin, mark: the command scans the 16 slots one per cycle, then resolves and writes;
// no new command is taken until it is done; a single result strobes at the end.
// Flush walks ages 0..SLOTS-1, each age a linear search of the slots plus a tag read.
// Results cannot be stalled by the receiver.
// Synchronous reset clears flags, ages, occupancy and sets capacity to 16.
`timescale 1ns / 1ps
module lru_page_buffer_policy (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [31:0] page_id,
  input  logic        dirty_flag,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [31:0] page_out,
  output logic        evicted,
  output logic [31:0] victim_page,
  output logic        evicted_dirty,
  output logic        load_from_disk,
  output logic        last
);
  localparam int SW = lrupb_pkg::SW;
  localparam int CW = lrupb_pkg::CW;
  localparam int SLOTS = lrupb_pkg::SLOTS;

  // command registers and scan state
  lrupb_pkg::state_t state, state_next;
  logic          strobe_next;
  logic [1:0]    cmd_r;
  logic [31:0]   page_id_r;
  logic          dflag_r;
  logic [CW-1:0] idx;       // scan index (one beyond last)
  logic [SW-1:0] si;
  logic          hit;
  logic [SW-1:0] hit_s, vic_s, free_s;
  logic          vic_f, free_f;
  logic [SW-1:0] fage;
  logic          cmp_v;
  logic [SW-1:0] cmp_s;
  logic          scan_end, flush_hit, flush_end, vic_take;

  // per-slot flags, ages, occupancy and capacity
  logic [SLOTS-1:0] valid, dirty;
  logic [SW-1:0] age [SLOTS];
  logic [CW-1:0] occ;
  logic [4:0]    cap;
  logic [CW-1:0] effcap;
  logic          evict_now;
  logic          ins_we;
  logic [SW-1:0] ins_slot;
  logic [31:0]   tag_mem_vic;

  // Tag memory: one write port, one registered read port
  logic [31:0] tag_mem [SLOTS];
  logic [31:0] tag_q;
  logic        tag_we;
  logic [SW-1:0] tag_waddr, tag_raddr;
  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_waddr] <= page_id_r;
    tag_q <= tag_mem[tag_raddr];
  end

  assign busy = (state != lrupb_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // effective capacity
  always_comb begin
    if (cap == 5'd0) effcap = CW'(1);
    else if (32'(cap) > SLOTS) effcap = CW'(SLOTS);
    else effcap = CW'(cap);
  end

  assign si = idx[SW-1:0];
  assign tag_raddr = (state == lrupb_pkg::S_SCAN || state == lrupb_pkg::S_FREAD) ? si : hit_s;
  assign tag_we = ins_we;
  assign tag_waddr = ins_slot;

  // scan pipeline: read issued at si, compare in the following cycle
  assign evict_now = (occ >= effcap);
  assign scan_end = (idx == CW'(SLOTS)) && !cmp_v;
  assign vic_take = (state == lrupb_pkg::S_SCAN) && cmp_v && valid[cmp_s] &&
                    (!vic_f || age[cmp_s] > age[vic_s]);
  assign flush_hit = valid[si] && age[si] == fage && dirty[si];
  assign flush_end = !flush_hit && idx == CW'(SLOTS-1) && fage == SW'(SLOTS-1);

  always_comb begin
    ins_we = 1'b0;
    ins_slot = free_s;
    if (state == lrupb_pkg::S_SCAN && scan_end && !hit &&
        (cmd_r == lrupb_pkg::CMD_GET || cmd_r == lrupb_pkg::CMD_PIN)) begin
      ins_we = 1'b1;
      ins_slot = evict_now ? vic_s : free_s;
    end
  end

  // next state and result strobe
  always_comb begin
    state_next = state;
    strobe_next = 1'b0;
    unique case (state)
      lrupb_pkg::S_IDLE: begin
        if (start) begin
          if (command == lrupb_pkg::CMD_FLUSH) state_next = lrupb_pkg::S_FREAD;
          else state_next = lrupb_pkg::S_SCAN;
        end
      end
      lrupb_pkg::S_SCAN: begin
        if (scan_end) begin
          state_next = lrupb_pkg::S_IDLE;
          strobe_next = 1'b1;
        end
      end
      lrupb_pkg::S_FREAD: begin
        if (flush_hit) begin
          state_next = lrupb_pkg::S_FEMIT;
        end else if (flush_end) begin
          state_next = lrupb_pkg::S_IDLE;
          strobe_next = 1'b1;
        end
      end
      lrupb_pkg::S_FEMIT: begin
        state_next = lrupb_pkg::S_FREAD;
        strobe_next = 1'b1;
      end
      default: state_next = lrupb_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= lrupb_pkg::S_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0; dirty <= '0; occ <= '0; cap <= 5'd16;
      for (int i = 0; i < SLOTS; i++) age[i] <= '0;
      strobe <= 1'b0; cmp_v <= 1'b0;
    end else begin
      strobe <= strobe_next;
      if (cfg_valid && cfg_ready) cap <= cfg_data;
      unique case (state)
        lrupb_pkg::S_IDLE: begin
          if (start) begin
            cmd_r <= command; page_id_r <= page_id; dflag_r <= dirty_flag;
            idx <= '0; hit <= 1'b0; free_f <= 1'b0; vic_f <= 1'b0; cmp_v <= 1'b0;
            vic_s <= '0; free_s <= '0; fage <= '0;
          end
        end
        lrupb_pkg::S_SCAN: begin
          // compare stage
          if (cmp_v) begin
            if (valid[cmp_s] && tag_q == page_id_r && !hit) begin
              hit <= 1'b1; hit_s <= cmp_s;
            end
            if (!valid[cmp_s] && !free_f) begin
              free_f <= 1'b1; free_s <= cmp_s;
            end
            if (vic_take) begin
              vic_f <= 1'b1; vic_s <= cmp_s;
            end
          end
          if (idx != CW'(SLOTS)) begin
            cmp_v <= 1'b1; cmp_s <= si; idx <= idx + CW'(1);
          end else if (cmp_v) begin
            cmp_v <= 1'b0;
          end else begin
            // resolve command
            last <= 1'b1; page_out <= page_id_r;
            evicted <= ins_we & evict_now;
            victim_page <= (ins_we && evict_now) ? tag_mem_vic : '0;
            evicted_dirty <= ins_we & evict_now & dirty[vic_s];
            load_from_disk <= ins_we && (cmd_r == lrupb_pkg::CMD_GET);
            if (cmd_r == lrupb_pkg::CMD_MARK) begin
              kind <= hit ? lrupb_pkg::K_MARKED : lrupb_pkg::K_ABSENT;
              if (hit) dirty[hit_s] <= 1'b1;
            end else if (hit) begin
              kind <= (cmd_r == lrupb_pkg::CMD_GET) ? lrupb_pkg::K_HIT : lrupb_pkg::K_PIN_UPD;
              if (cmd_r == lrupb_pkg::CMD_PIN) dirty[hit_s] <= dflag_r;
              for (int i = 0; i < SLOTS; i++)
                if (valid[i] && SW'(i) != hit_s && age[i] < age[hit_s]) age[i] <= age[i] + 1'b1;
              age[hit_s] <= '0;
            end else begin
              kind <= (cmd_r == lrupb_pkg::CMD_GET) ? lrupb_pkg::K_MISS : lrupb_pkg::K_PIN_INS;
              for (int i = 0; i < SLOTS; i++)
                if (valid[i] && SW'(i) != ins_slot) age[i] <= age[i] + 1'b1;
              age[ins_slot] <= '0;
              valid[ins_slot] <= 1'b1;
              dirty[ins_slot] <= (cmd_r == lrupb_pkg::CMD_PIN) & dflag_r;
              if (!evict_now) occ <= occ + CW'(1);
            end
          end
        end
        lrupb_pkg::S_FREAD: begin
          // search for a dirty slot holding age fage, one slot per cycle except while a write-back is emitted
          if (flush_hit) begin
            hit_s <= si;
          end else if (idx == CW'(SLOTS-1)) begin
            idx <= '0;
            if (fage == SW'(SLOTS-1)) begin
              kind <= lrupb_pkg::K_FLUSH_DONE; last <= 1'b1;
              page_out <= '0; evicted <= 1'b0; victim_page <= '0;
              evicted_dirty <= 1'b0; load_from_disk <= 1'b0;
            end else fage <= fage + 1'b1;
          end else idx <= idx + CW'(1);
        end
        lrupb_pkg::S_FEMIT: begin
          kind <= lrupb_pkg::K_FLUSH_WB; last <= 1'b0;
          page_out <= tag_q; evicted <= 1'b0; victim_page <= '0;
          evicted_dirty <= 1'b0; load_from_disk <= 1'b0;
          dirty[hit_s] <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // victim tag captured during the scan
  always_ff @(posedge clk) begin
    if (state == lrupb_pkg::S_IDLE) tag_mem_vic <= '0;
    else if (vic_take) tag_mem_vic <= tag_q;
  end
endmodule

@@ hw/rtl/lrupb_checker.sv @@
// Port-level checks for the LRU page buffer; bound to the top level.
// Depends on lrupb_pkg.
`timescale 1ns / 1ps
module lrupb_checker (
  input logic clk, input logic rst, input logic start, input logic busy,
  input logic strobe, input logic [2:0] kind, input logic last,
  input logic evicted, input logic [31:0] victim_page, input logic load_from_disk
);
  a_idle_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("start not taken");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy) else $error("busy at last");
  a_load: assert property (@(posedge clk) disable iff (rst)
    strobe && load_from_disk |-> kind == lrupb_pkg::K_MISS) else $error("load kind");
  a_wb: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == lrupb_pkg::K_FLUSH_WB |-> !last) else $error("wb last");
  a_noev: assert property (@(posedge clk) disable iff (rst)
    strobe && !evicted |-> victim_page == 32'd0) else $error("evicted page");
endmodule

bind lru_page_buffer_policy lrupb_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .strobe(strobe), .kind(kind),
  .last(last), .evicted(evicted), .victim_page(victim_page),
  .load_from_disk(load_from_disk)
);
